// File: sv/position_history_cursor_assert.svh
// assertion macros for the position history cursor datapath
// needs i_clk and i_rst_n in the scope where a macro is used
`ifndef POSITION_HISTORY_CURSOR_ASSERT_SVH
`define POSITION_HISTORY_CURSOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PHC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define PHC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define PHC_ASSERT(label, prop, msg)
`define PHC_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// File: sv/phc_pkg.sv
// types and constants for the position history cursor
// used by the controller, the datapath and the top level
package phc_pkg;

    localparam int DEPTH_DEF = 128;
    localparam int MODE_W    = 3;
    localparam int PAGE_W    = 10;
    localparam int LINE_W    = 24;
    localparam int COL_W     = 16;
    localparam int USED_W    = 8;

    localparam logic [MODE_W-1:0] MODE_ADD   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_BACK  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FWD   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CLOSE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_QUERY = 3'd4;

    typedef struct packed {
        logic [PAGE_W-1:0] page;
        logic [LINE_W-1:0] line;
        logic [COL_W-1:0]  col;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_ADD_RD,
        S_ADD_CMP,
        S_NAV,
        S_CLOSE,
        S_CLOSE_END,
        S_OUT_RD,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic add_cmp;
        logic nav;
        logic close_step;
        logic close_fin;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              close_done;
    } t_sts;

endpackage

// File: sv/phc_ram.sv
// generic single write port ram with registered read
// no package dependencies
module phc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/phc_ctrl.sv
// controller state machine of the position history cursor
// depends on phc_pkg for state, command and status types
module phc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  phc_pkg::t_sts i_sts,
    output phc_pkg::t_cmd o_cmd
);
    import phc_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        busy    = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_sts.mode) inside
                    MODE_ADD:            n_state = S_ADD_RD;
                    MODE_BACK, MODE_FWD: n_state = S_NAV;
                    MODE_CLOSE:          n_state = S_CLOSE;
                    default:             n_state = S_OUT_RD;
                endcase
            end
            S_ADD_RD: begin
                n_state = S_ADD_CMP;
            end
            S_ADD_CMP: begin
                o_cmd.add_cmp = 1'b1;
                n_state       = S_OUT_RD;
            end
            S_NAV: begin
                o_cmd.nav = 1'b1;
                n_state   = S_OUT_RD;
            end
            S_CLOSE: begin
                if (i_sts.close_done) begin
                    n_state = S_CLOSE_END;
                end else begin
                    o_cmd.close_step = 1'b1;
                end
            end
            S_CLOSE_END: begin
                o_cmd.close_fin = 1'b1;
                n_state         = S_OUT_RD;
            end
            S_OUT_RD: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                o_cmd.emit = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: sv/phc_dp.sv
// datapath of the position history cursor: ring store, cursor, compaction
// depends on phc_pkg, phc_ram and the assertion macro header
`include "position_history_cursor_assert.svh"
module phc_dp #(
    parameter int DEPTH = phc_pkg::DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  phc_pkg::t_cmd                i_cmd,
    output phc_pkg::t_sts                o_sts,
    input  logic [phc_pkg::MODE_W-1:0]   i_mode,
    input  logic [phc_pkg::PAGE_W-1:0]   i_page_id,
    input  logic [phc_pkg::LINE_W-1:0]   i_line_number,
    input  logic [phc_pkg::COL_W-1:0]    i_column,
    output logic                         o_valid,
    output logic                         o_has_position,
    output logic                         o_moved,
    output logic [phc_pkg::PAGE_W-1:0]   o_out_page,
    output logic [phc_pkg::LINE_W-1:0]   o_out_line,
    output logic [phc_pkg::COL_W-1:0]    o_out_column,
    output logic [phc_pkg::USED_W-1:0]   o_used_entries
);
    import phc_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                              input logic [AW-1:0] lg);
        logic [AW:0] s;
        s = {1'b0, base} + {1'b0, lg};
        if (s >= (AW+1)'(DEPTH)) begin
            s = s - (AW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    // input item
    logic [MODE_W-1:0] r_mode;
    logic [PAGE_W-1:0] r_page;
    logic [LINE_W-1:0] r_line;
    logic [COL_W-1:0]  r_col;

    // history control
    logic [AW-1:0] r_oldest, n_oldest;
    logic [CW-1:0] r_total,  n_total;
    logic [AW-1:0] r_cur,    n_cur;
    logic          r_cv,     n_cv;
    logic          r_moved,  n_moved;

    // compaction
    logic [CW-1:0] r_rd,     n_rd;
    logic          r_pend,   n_pend;
    logic [AW-1:0] r_pidx,   n_pidx;
    logic [CW-1:0] r_w,      n_w;
    logic          r_found,  n_found;
    logic [AW-1:0] r_newcur, n_newcur;

    // result
    logic              r_strobe, n_strobe;
    logic              r_out_has;
    logic              r_out_moved;
    t_entry            r_out_entry;
    logic [USED_W-1:0] r_out_used;

    logic             we;
    logic [AW-1:0]    waddr;
    t_entry           wdata;
    logic [AW-1:0]    raddr;
    logic [ENTRY_W-1:0] rdata_raw;
    t_entry           rdata;

    logic          cur_ok;
    logic [CW-1:0] tgt;
    logic [AW-1:0] oldest_nx;
    logic [CW-1:0] total_m1;
    logic [CW-1:0] w_m1;
    logic [CW+USED_W-1:0] used_ext;

    phc_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata_raw)
    );

    assign rdata    = t_entry'(rdata_raw);
    assign cur_ok   = r_cv && (CW'(r_cur) < r_total);
    assign total_m1 = r_total - CW'(1);
    assign w_m1     = r_w - CW'(1);
    assign used_ext = (CW+USED_W)'(r_total);

    assign o_sts.mode       = r_mode;
    assign o_sts.close_done = (r_rd == r_total) && !r_pend;

    always_comb begin
        n_oldest  = r_oldest;
        n_total   = r_total;
        n_cur     = r_cur;
        n_cv      = r_cv;
        n_moved   = r_moved;
        n_rd      = r_rd;
        n_pend    = r_pend;
        n_pidx    = r_pidx;
        n_w       = r_w;
        n_found   = r_found;
        n_newcur  = r_newcur;
        n_strobe  = 1'b0;
        we        = 1'b0;
        waddr     = slot_of(r_oldest, r_cur);
        wdata     = rdata;
        raddr     = slot_of(r_oldest, r_cur);
        tgt       = r_total;
        oldest_nx = r_oldest;

        if (i_cmd.load) begin
            n_moved = 1'b0;
            n_rd    = '0;
            n_pend  = 1'b0;
            n_w     = '0;
            n_found = 1'b0;
        end

        if (i_cmd.add_cmp) begin
            wdata = '{page: r_page, line: r_line, col: r_col};
            we    = 1'b1;
            if (cur_ok && rdata.page == r_page && rdata.line == r_line) begin
                waddr = slot_of(r_oldest, r_cur);
            end else begin
                // drop newer entries, evict oldest when full
                tgt = cur_ok ? (CW'(r_cur) + CW'(1)) : r_total;
                if (tgt >= CW'(DEPTH)) begin
                    oldest_nx = (r_oldest == AW'(DEPTH - 1)) ? '0 : (r_oldest + AW'(1));
                    tgt       = CW'(DEPTH - 1);
                end
                waddr    = slot_of(oldest_nx, tgt[AW-1:0]);
                n_oldest = oldest_nx;
                n_total  = tgt + CW'(1);
                n_cur    = tgt[AW-1:0];
                n_cv     = 1'b1;
            end
        end

        if (i_cmd.nav) begin
            if (r_mode == MODE_BACK) begin
                if (r_cv) begin
                    if (r_cur != '0 && cur_ok) begin
                        n_cur   = r_cur - AW'(1);
                        n_moved = 1'b1;
                    end
                end else if (r_total != '0) begin
                    n_cur   = total_m1[AW-1:0];
                    n_cv    = 1'b1;
                    n_moved = 1'b1;
                end
            end else if (r_mode == MODE_FWD) begin
                if (r_cv && (CW'(r_cur) + CW'(1) < r_total)) begin
                    n_cur   = r_cur + AW'(1);
                    n_moved = 1'b1;
                end
            end
        end

        if (i_cmd.close_step) begin
            // check the entry read last cycle, keep it unless its page closed
            if (r_pend && rdata.page != r_page) begin
                if (r_cv && !r_found && r_pidx >= r_cur) begin
                    n_newcur = r_w[AW-1:0];
                    n_found  = 1'b1;
                end
                if (r_w != CW'(r_pidx)) begin
                    we    = 1'b1;
                    waddr = slot_of(r_oldest, r_w[AW-1:0]);
                    wdata = rdata;
                end
                n_w = r_w + CW'(1);
            end
            if (r_rd < r_total) begin
                raddr  = slot_of(r_oldest, r_rd[AW-1:0]);
                n_pend = 1'b1;
                n_pidx = r_rd[AW-1:0];
                n_rd   = r_rd + CW'(1);
            end else begin
                n_pend = 1'b0;
            end
        end

        if (i_cmd.close_fin) begin
            n_total = r_w;
            if (!r_cv || r_w == '0) begin
                n_cv  = 1'b0;
                n_cur = '0;
            end else begin
                n_cur = r_found ? r_newcur : w_m1[AW-1:0];
            end
        end

        if (i_cmd.emit) begin
            n_strobe = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oldest <= '0;
            r_total  <= '0;
            r_cur    <= '0;
            r_cv     <= 1'b0;
            r_moved  <= 1'b0;
            r_rd     <= '0;
            r_pend   <= 1'b0;
            r_pidx   <= '0;
            r_w      <= '0;
            r_found  <= 1'b0;
            r_newcur <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_oldest <= n_oldest;
            r_total  <= n_total;
            r_cur    <= n_cur;
            r_cv     <= n_cv;
            r_moved  <= n_moved;
            r_rd     <= n_rd;
            r_pend   <= n_pend;
            r_pidx   <= n_pidx;
            r_w      <= n_w;
            r_found  <= n_found;
            r_newcur <= n_newcur;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_mode;
            r_page <= i_page_id;
            r_line <= i_line_number;
            r_col  <= i_column;
        end
        if (i_cmd.emit) begin
            r_out_has   <= cur_ok;
            r_out_moved <= r_moved;
            r_out_entry <= cur_ok ? rdata : '0;
            r_out_used  <= used_ext[USED_W-1:0];
        end
    end

    assign o_valid        = r_strobe;
    assign o_has_position = r_out_has;
    assign o_moved        = r_out_moved;
    assign o_out_page     = r_out_entry.page;
    assign o_out_line     = r_out_entry.line;
    assign o_out_column   = r_out_entry.col;
    assign o_used_entries = r_out_used;

    `PHC_ASSERT(a_cursor_in_range, r_cv |-> (CW'(r_cur) < r_total), "cursor beyond newest entry")
    `PHC_ASSERT(a_total_bounded, r_total <= CW'(DEPTH), "entry count above depth")
    `PHC_ASSERT(a_compact_order, (i_cmd.close_step && r_pend) |-> (r_w <= CW'(r_pidx)), "compaction write ahead of read")
    `PHC_ASSERT(a_strobe_single, r_strobe |=> !r_strobe, "result strobe longer than one cycle")
    `PHC_ASSERT_ALWAYS(a_reset_clear, !i_rst_n |=> (!r_strobe && !r_cv && r_total == '0), "state not cleared by reset")

endmodule

// File: sv/position_history_cursor.sv
// steps per item: decode, then by mode a store read and compare (add), a cursor step
// (back or forward) or a sweep that compacts the held entries, one entry per cycle
// (page closed); every mode then reads the cursor entry and raises the result strobe
// one item at a time: the next item is taken at the edge that ends the result strobe;
// results cannot be stalled
// reset (synchronous, active low) empties history and cursor; store contents are kept
module position_history_cursor #(
    parameter int DEPTH = phc_pkg::DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [phc_pkg::MODE_W-1:0]   i_mode,
    input  logic [phc_pkg::PAGE_W-1:0]   i_page_id,
    input  logic [phc_pkg::LINE_W-1:0]   i_line_number,
    input  logic [phc_pkg::COL_W-1:0]    i_column,
    output logic                         o_valid,
    output logic                         o_has_position,
    output logic                         o_moved,
    output logic [phc_pkg::PAGE_W-1:0]   o_out_page,
    output logic [phc_pkg::LINE_W-1:0]   o_out_line,
    output logic [phc_pkg::COL_W-1:0]    o_out_column,
    output logic [phc_pkg::USED_W-1:0]   o_used_entries
);
    import phc_pkg::*;

    t_cmd cmd;
    t_sts sts;

    phc_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .busy   (busy),
        .i_sts  (sts),
        .o_cmd  (cmd)
    );

    phc_dp #(
        .DEPTH(DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_mode        (i_mode),
        .i_page_id     (i_page_id),
        .i_line_number (i_line_number),
        .i_column      (i_column),
        .o_valid       (o_valid),
        .o_has_position(o_has_position),
        .o_moved       (o_moved),
        .o_out_page    (o_out_page),
        .o_out_line    (o_out_line),
        .o_out_column  (o_out_column),
        .o_used_entries(o_used_entries)
    );

endmodule

// File: tb/position_history_cursor_test.sv
// testbench for position_history_cursor: directed table then phased random commands,
// every result checked against its table value or a cycle-free model of the navigation history
// depends on phc_pkg and the position_history_cursor top level
module position_history_cursor_test;
    import phc_pkg::*;

    localparam int                HIST_DEPTH     = DEPTH_DEF;
    localparam int                RANDOM_ITEMS   = 1830;
    localparam int                PHASE_LEN      = 250;
    localparam int                STALL_LIMIT    = 2000;
    localparam int                DRAIN_CYCLES   = 150;
    localparam logic [MODE_W-1:0] MODE_SPARE_LO  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI  = 3'd7;

    typedef struct packed {
        logic              has_pos;
        logic              moved;
        logic [PAGE_W-1:0] page;
        logic [LINE_W-1:0] line;
        logic [COL_W-1:0]  col;
        logic [USED_W-1:0] used;
    } t_cursor_result;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [PAGE_W-1:0] page;
        logic [LINE_W-1:0] line;
        logic [COL_W-1:0]  col;
        logic              known;
        t_cursor_result    want;
    } t_nav_row;

    localparam t_cursor_result NO_POSITION = '0;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [MODE_W-1:0] i_mode = MODE_QUERY;
    logic [PAGE_W-1:0] i_page_id = '0;
    logic [LINE_W-1:0] i_line_number = '0;
    logic [COL_W-1:0]  i_column = '0;
    logic              o_valid;
    logic              o_has_position;
    logic              o_moved;
    logic [PAGE_W-1:0] o_out_page;
    logic [LINE_W-1:0] o_out_line;
    logic [COL_W-1:0]  o_out_column;
    logic [USED_W-1:0] o_used_entries;

    t_entry         history [HIST_DEPTH];
    int unsigned    ring_head = 0;
    int unsigned    held = 0;
    int unsigned    cur = 0;
    bit             cur_ok = 1'b0;
    t_cursor_result cursor_results_due [$];
    t_nav_row       directed_rows [$];
    int             burst_left = 8;
    int             errors = 0;
    int             idle_cycles = 0;

    position_history_cursor dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_mode         (i_mode),
        .i_page_id      (i_page_id),
        .i_line_number  (i_line_number),
        .i_column       (i_column),
        .o_valid        (o_valid),
        .o_has_position (o_has_position),
        .o_moved        (o_moved),
        .o_out_page     (o_out_page),
        .o_out_line     (o_out_line),
        .o_out_column   (o_out_column),
        .o_used_entries (o_used_entries)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int unsigned ring_slot(int unsigned pos);
        return (ring_head + pos) % HIST_DEPTH;
    endfunction

    function automatic t_cursor_result step_history(logic [MODE_W-1:0] mode,
            logic [PAGE_W-1:0] page, logic [LINE_W-1:0] line, logic [COL_W-1:0] col);
        t_cursor_result res;
        int unsigned    s;
        int unsigned    i;
        int unsigned    w;
        int unsigned    newcur;
        bit             found;
        bit             refreshed;
        bit             moved;
        moved = 1'b0;
        case (mode)
            MODE_ADD: begin
                refreshed = 1'b0;
                if (cur_ok && cur < held) begin
                    s = ring_slot(cur);
                    if (history[s].page == page && history[s].line == line) begin
                        history[s].col = col;
                        refreshed = 1'b1;
                    end else begin
                        held = cur + 1;
                    end
                end
                if (!refreshed) begin
                    if (held >= HIST_DEPTH) begin
                        ring_head = (ring_head + 1) % HIST_DEPTH;
                        held = HIST_DEPTH - 1;
                    end
                    s = ring_slot(held);
                    history[s].page = page;
                    history[s].line = line;
                    history[s].col = col;
                    held++;
                    cur = held - 1;
                    cur_ok = 1'b1;
                end
            end
            MODE_BACK: begin
                if (cur_ok) begin
                    if (cur > 0 && cur < held) begin
                        cur--;
                        moved = 1'b1;
                    end
                end else if (held > 0) begin
                    cur = held - 1;
                    cur_ok = 1'b1;
                    moved = 1'b1;
                end
            end
            MODE_FWD: begin
                if (cur_ok && cur + 1 < held) begin
                    cur++;
                    moved = 1'b1;
                end
            end
            MODE_CLOSE: begin
                w = 0;
                newcur = 0;
                found = 1'b0;
                for (i = 0; i < held; i++) begin
                    if (history[ring_slot(i)].page != page) begin
                        if (cur_ok && !found && i >= cur) begin
                            newcur = w;
                            found = 1'b1;
                        end
                        if (w != i)
                            history[ring_slot(w)] = history[ring_slot(i)];
                        w++;
                    end
                end
                held = w;
                if (!cur_ok || w == 0) begin
                    cur_ok = 1'b0;
                    cur = 0;
                end else begin
                    cur = found ? newcur : w - 1;
                end
            end
            default: ;
        endcase
        res = NO_POSITION;
        if (cur_ok && cur < held) begin
            s = ring_slot(cur);
            res.has_pos = 1'b1;
            res.page = history[s].page;
            res.line = history[s].line;
            res.col = history[s].col;
        end
        res.moved = moved;
        res.used = USED_W'(held);
        return res;
    endfunction

    function automatic t_nav_row nav_row(logic [MODE_W-1:0] mode, logic [PAGE_W-1:0] page,
            logic [LINE_W-1:0] line, logic [COL_W-1:0] col, logic known,
            t_cursor_result want);
        t_nav_row r;
        r.mode = mode;
        r.page = page;
        r.line = line;
        r.col = col;
        r.known = known;
        r.want = want;
        return r;
    endfunction

    task automatic send_command(logic [MODE_W-1:0] mode, logic [PAGE_W-1:0] page,
            logic [LINE_W-1:0] line, logic [COL_W-1:0] col, logic known,
            t_cursor_result want);
        t_cursor_result predicted;
        start <= 1'b1;
        i_mode <= mode;
        i_page_id <= page;
        i_line_number <= line;
        i_column <= col;
        do @(posedge i_clk); while (busy);
        predicted = step_history(mode, page, line, col);
        cursor_results_due.push_back(known ? want : predicted);
        burst_left--;
        if (burst_left <= 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 16);
        end
    endtask

    // result check, sampled mid-cycle so transfers queued at the edge are settled
    always @(negedge i_clk) begin
        t_cursor_result want;
        if (i_rst_n && o_valid) begin
            if (cursor_results_due.size() == 0) begin
                $error("result transfer with no expectation pending");
                errors++;
            end else begin
                want = cursor_results_due.pop_front();
                if (o_has_position !== want.has_pos) begin
                    $error("has_position expected %0d got %0d", want.has_pos, o_has_position);
                    errors++;
                end
                if (o_moved !== want.moved) begin
                    $error("moved expected %0d got %0d", want.moved, o_moved);
                    errors++;
                end
                if (o_out_page !== want.page) begin
                    $error("out_page expected %0d got %0d", want.page, o_out_page);
                    errors++;
                end
                if (o_out_line !== want.line) begin
                    $error("out_line expected %0d got %0d", want.line, o_out_line);
                    errors++;
                end
                if (o_out_column !== want.col) begin
                    $error("out_column expected %0d got %0d", want.col, o_out_column);
                    errors++;
                end
                if (o_used_entries !== want.used) begin
                    $error("used_entries expected %0d got %0d", want.used, o_used_entries);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("position_history_cursor verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        int                n;
        int                phase;
        int                roll;
        logic [MODE_W-1:0] mode;
        logic [PAGE_W-1:0] page;
        logic [LINE_W-1:0] line;
        logic [COL_W-1:0]  col;
        t_entry            here;
        t_nav_row          r;

        directed_rows.push_back(nav_row(MODE_QUERY, '0, '0, '0, 1'b1, NO_POSITION));
        directed_rows.push_back(nav_row(MODE_BACK, '0, '0, '0, 1'b1, NO_POSITION));
        directed_rows.push_back(nav_row(MODE_FWD, '0, '0, '0, 1'b1, NO_POSITION));
        directed_rows.push_back(nav_row(MODE_CLOSE, 10'd1023, '0, '0, 1'b1, NO_POSITION));
        directed_rows.push_back(nav_row(MODE_SPARE_HI, '1, '1, '1, 1'b1, NO_POSITION));
        directed_rows.push_back(nav_row(MODE_ADD, 10'd1023, 24'hFFFFFF, 16'hFFFF, 1'b1,
            '{1'b1, 1'b0, 10'd1023, 24'hFFFFFF, 16'hFFFF, 8'd1}));
        directed_rows.push_back(nav_row(MODE_ADD, 10'd1023, 24'hFFFFFF, 16'h0000, 1'b1,
            '{1'b1, 1'b0, 10'd1023, 24'hFFFFFF, 16'h0000, 8'd1}));
        directed_rows.push_back(nav_row(MODE_ADD, '0, '0, '0, 1'b1,
            '{1'b1, 1'b0, 10'd0, 24'd0, 16'd0, 8'd2}));
        directed_rows.push_back(nav_row(MODE_ADD, '0, '0, 16'hFFFF, 1'b1,
            '{1'b1, 1'b0, 10'd0, 24'd0, 16'hFFFF, 8'd2}));
        directed_rows.push_back(nav_row(MODE_ADD, 10'd512, 24'h800000, 16'h8000, 1'b1,
            '{1'b1, 1'b0, 10'd512, 24'h800000, 16'h8000, 8'd3}));
        directed_rows.push_back(nav_row(MODE_FWD, '0, '0, '0, 1'b1,
            '{1'b1, 1'b0, 10'd512, 24'h800000, 16'h8000, 8'd3}));
        directed_rows.push_back(nav_row(MODE_BACK, '0, '0, '0, 1'b1,
            '{1'b1, 1'b1, 10'd0, 24'd0, 16'hFFFF, 8'd3}));
        directed_rows.push_back(nav_row(MODE_BACK, '0, '0, '0, 1'b1,
            '{1'b1, 1'b1, 10'd1023, 24'hFFFFFF, 16'h0000, 8'd3}));
        directed_rows.push_back(nav_row(MODE_BACK, '0, '0, '0, 1'b1,
            '{1'b1, 1'b0, 10'd1023, 24'hFFFFFF, 16'h0000, 8'd3}));
        directed_rows.push_back(nav_row(MODE_FWD, '0, '0, '0, 1'b0, NO_POSITION));
        directed_rows.push_back(nav_row(MODE_ADD, 10'd7, 24'h123456, 16'h55AA, 1'b0,
            NO_POSITION));
        directed_rows.push_back(nav_row(MODE_SPARE_LO, '0, '0, '0, 1'b0, NO_POSITION));
        directed_rows.push_back(nav_row(MODE_BACK, '0, '0, '0, 1'b0, NO_POSITION));
        directed_rows.push_back(nav_row(MODE_CLOSE, 10'd0, '0, '0, 1'b0, NO_POSITION));
        directed_rows.push_back(nav_row(MODE_CLOSE, 10'd7, '0, '0, 1'b0, NO_POSITION));
        directed_rows.push_back(nav_row(MODE_CLOSE, 10'd1023, '0, '0, 1'b1, NO_POSITION));
        directed_rows.push_back(nav_row(MODE_BACK, '0, '0, '0, 1'b1, NO_POSITION));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            r = directed_rows[k];
            send_command(r.mode, r.page, r.line, r.col, r.known, r.want);
        end

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % PHASE_LEN == 0) begin
                start <= 1'b0;
                do @(posedge i_clk); while (cursor_results_due.size() != 0);
            end
            phase = (n / PHASE_LEN) % 3;
            roll = $urandom_range(0, 99);
            mode = MODE_QUERY;
            page = PAGE_W'($urandom_range(0, 1023));
            line = LINE_W'($urandom);
            col = COL_W'($urandom_range(0, 65535));
            here = '0;
            if (cur_ok && cur < held)
                here = history[ring_slot(cur)];
            case (phase)
                0: begin
                    if (roll < 82)      mode = MODE_ADD;
                    else if (roll < 88) mode = MODE_BACK;
                    else if (roll < 92) mode = MODE_FWD;
                    else if (roll < 95) mode = MODE_CLOSE;
                    else mode = MODE_W'($urandom_range(MODE_QUERY, MODE_SPARE_HI));
                end
                1: begin
                    if (roll < 35) begin
                        mode = MODE_ADD;
                        page = PAGE_W'($urandom_range(0, 7));
                    end else if (roll < 45) begin
                        mode = MODE_ADD;
                        if (cur_ok) begin
                            page = here.page;
                            line = here.line;
                        end
                    end else if (roll < 62) begin
                        mode = MODE_BACK;
                    end else if (roll < 75) begin
                        mode = MODE_FWD;
                    end else if (roll < 90) begin
                        mode = MODE_CLOSE;
                        page = PAGE_W'($urandom_range(0, 7));
                    end else begin
                        mode = MODE_W'($urandom_range(MODE_QUERY, MODE_SPARE_HI));
                    end
                end
                default: begin
                    if (roll < 30) begin
                        mode = MODE_BACK;
                    end else if (roll < 55) begin
                        mode = MODE_FWD;
                    end else if (roll < 70) begin
                        mode = MODE_ADD;
                        if (cur_ok) begin
                            page = here.page;
                            line = here.line;
                        end
                    end else if (roll < 85) begin
                        mode = MODE_ADD;
                        page = PAGE_W'($urandom_range(0, 7));
                    end else if (roll < 92) begin
                        mode = MODE_CLOSE;
                        if (cur_ok && roll < 90)
                            page = here.page;
                    end else begin
                        mode = MODE_W'($urandom_range(MODE_QUERY, MODE_SPARE_HI));
                    end
                end
            endcase
            send_command(mode, page, line, col, 1'b0, NO_POSITION);
        end

        start <= 1'b0;
        do @(posedge i_clk); while (cursor_results_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && cursor_results_due.size() == 0)
            $display("position_history_cursor verification clean");
        else
            $display("position_history_cursor verification failed");
        $finish;
    end

endmodule
